FILE: hdl/mesi_pkg.sv
// ----------------------------------------------------------------------------
// MESI cache package
// Command codes, line states, sequencer states and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package mesi_pkg;

  localparam logic [2:0] CMD_RD_WORD = 3'd0;
  localparam logic [2:0] CMD_WR_WORD = 3'd1;
  localparam logic [2:0] CMD_RD_LINE = 3'd2;
  localparam logic [2:0] CMD_FILL    = 3'd3;
  localparam logic [2:0] CMD_SNOOP   = 3'd4;

  localparam logic [1:0] MESI_I = 2'd0;
  localparam logic [1:0] MESI_S = 2'd1;
  localparam logic [1:0] MESI_E = 2'd2;
  localparam logic [1:0] MESI_M = 2'd3;

  localparam logic [1:0] SNOOP_BUS_RD = 2'd0;
  localparam logic [1:0] SNOOP_BUS_WR = 2'd1;

  localparam logic [1:0] SRES_ABSENT  = 2'd0;
  localparam logic [1:0] SRES_PRESENT = 2'd1;
  localparam logic [1:0] SRES_FLUSH   = 2'd2;

  localparam int unsigned TAG_W  = 14;
  localparam int unsigned WORD_W = 64;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_TAG,
    FSM_FILL,
    FSM_ACT,
    FSM_RD,
    FSM_EMIT,
    FSM_ONE
  } fsm_e;

  typedef struct packed {
    logic              hit;
    logic [WORD_W-1:0] data;
    logic [1:0]        widx;
    logic              wb;
    logic [15:0]       wbaddr;
    logic [1:0]        snoop;
    logic              last;
    logic [31:0]       mcnt;
    logic [31:0]       icnt;
  } out_t;

endpackage

`default_nettype wire

FILE: hdl/mesi_ram.sv
// ----------------------------------------------------------------------------
// MESI cache generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mesi_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mesi_fully_assoc_cache_fifo.sv
// ----------------------------------------------------------------------------
// MESI fully associative cache with FIFO replacement
// Four-word lines with per-line MESI state, snoop handling and writeback.
// ----------------------------------------------------------------------------
//  Channel   Dir  Signals                            Carries
//  s_axis    in   tvalid tready tdata tuser          one command item
//  m_axis    out  tvalid tready tdata tuser tlast    one result item
//
// The tag lookup compares one line per cycle in a shared comparator fed by the
// tag RAM and stops at the first valid matching line, or after the last line.
// Each data word is read in FSM_RD and then emitted in FSM_EMIT; a clean fill
// only writes the new words, and a dirty fill also emits each old word as a writeback.
// Reset clears all line states at once; no clearing pass is needed.
// A stalled result is held in the output register and stalls the sequencer.
`default_nettype none

module mesi_fully_assoc_cache_fifo #(
  parameter int unsigned LINES = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // address, data_word0, data_word1, data_word2, data_word3, new_state, zero pad
  input  wire logic [279:0] s_axis_tdata_i,
  // command, snoop_kind
  input  wire logic [4:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // hit, data_out, word_index, writeback_address, snoop_result, miss_count,
  // invalidation_count, zero pad
  output logic [151:0]      m_axis_tdata_o,
  // writeback
  output logic [0:0]        m_axis_tuser_o,
  output logic              m_axis_tlast_o
);

  localparam int unsigned IW  = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned DAW = $clog2(LINES * 4);
  localparam logic [IW-1:0] LAST_LINE = IW'(LINES - 1);

  mesi_pkg::fsm_e fsm_q, fsm_d;

  logic [2:0]                  cmd_q, cmd_d;
  logic [15:0]                 addr_q, addr_d;
  logic [mesi_pkg::WORD_W-1:0] word_q [4];
  logic [1:0]                  nst_q, nst_d;
  logic [1:0]                  kind_q, kind_d;

  logic [1:0]    st_q [LINES];
  logic [IW-1:0] scan_q, scan_d;
  logic [IW-1:0] cmp_q, cmp_d;
  logic          cmp_v_q, cmp_v_d;
  logic [IW-1:0] line_q, line_d;
  logic          found_q, found_d;
  logic [1:0]    w_q, w_d;
  logic          fill_q, fill_d;
  logic          single_q, single_d;
  logic          dirty_q, dirty_d;
  logic [15:0]   wbaddr_q, wbaddr_d;
  logic [IW-1:0] fifo_q, fifo_d;
  logic [31:0]   miss_q, miss_d;
  logic [31:0]   inv_q, inv_d;

  mesi_pkg::out_t pend_q, pend_d;
  mesi_pkg::out_t out_q, out_d;
  logic           ovalid_q, ovalid_d;

  logic                        st_we;
  logic [IW-1:0]               st_widx;
  logic [1:0]                  st_wdata;
  logic [IW-1:0]               st_sel;
  logic [1:0]                  st_rd;

  logic                        tag_we, tag_re;
  logic [IW-1:0]               tag_waddr, tag_raddr;
  logic [mesi_pkg::TAG_W-1:0]  tag_rdata;

  logic                        dat_we, dat_re;
  logic [DAW-1:0]              dat_addr;
  logic [mesi_pkg::WORD_W-1:0] dat_wdata, dat_rdata;

  logic in_acc, out_free, match;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !ovalid_q || m_axis_tready_i;
  assign st_rd    = st_q[st_sel];
  assign match    = (st_rd != mesi_pkg::MESI_I) && (tag_rdata == addr_q[15:2]);

  mesi_ram #(
    .WIDTH(mesi_pkg::TAG_W),
    .DEPTH(LINES),
    .AW   (IW)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (tag_we),
    .waddr_i(tag_waddr),
    .wdata_i(addr_q[15:2]),
    .re_i   (tag_re),
    .raddr_i(tag_raddr),
    .rdata_o(tag_rdata)
  );

  mesi_ram #(
    .WIDTH(mesi_pkg::WORD_W),
    .DEPTH(LINES * 4),
    .AW   (DAW)
  ) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (dat_we),
    .waddr_i(dat_addr),
    .wdata_i(dat_wdata),
    .re_i   (dat_re),
    .raddr_i(dat_addr),
    .rdata_o(dat_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q    <= mesi_pkg::FSM_IDLE;
      ovalid_q <= 1'b0;
      fifo_q   <= '0;
      miss_q   <= '0;
      inv_q    <= '0;
      for (int i = 0; i < LINES; i++) begin
        st_q[i] <= mesi_pkg::MESI_I;
      end
    end else begin
      fsm_q    <= fsm_d;
      ovalid_q <= ovalid_d;
      fifo_q   <= fifo_d;
      miss_q   <= miss_d;
      inv_q    <= inv_d;
      if (st_we) begin
        st_q[st_widx] <= st_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    addr_q   <= addr_d;
    nst_q    <= nst_d;
    kind_q   <= kind_d;
    scan_q   <= scan_d;
    cmp_q    <= cmp_d;
    cmp_v_q  <= cmp_v_d;
    line_q   <= line_d;
    found_q  <= found_d;
    w_q      <= w_d;
    fill_q   <= fill_d;
    single_q <= single_d;
    dirty_q  <= dirty_d;
    wbaddr_q <= wbaddr_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
    if (in_acc) begin
      word_q[0] <= s_axis_tdata_i[79:16];
      word_q[1] <= s_axis_tdata_i[143:80];
      word_q[2] <= s_axis_tdata_i[207:144];
      word_q[3] <= s_axis_tdata_i[271:208];
    end
  end

  always_comb begin
    fsm_d    = fsm_q;
    cmd_d    = cmd_q;
    addr_d   = addr_q;
    nst_d    = nst_q;
    kind_d   = kind_q;
    scan_d   = scan_q;
    cmp_d    = cmp_q;
    cmp_v_d  = cmp_v_q;
    line_d   = line_q;
    found_d  = found_q;
    w_d      = w_q;
    fill_d   = fill_q;
    single_d = single_q;
    dirty_d  = dirty_q;
    wbaddr_d = wbaddr_q;
    fifo_d   = fifo_q;
    miss_d   = miss_q;
    inv_d    = inv_q;
    pend_d   = pend_q;
    out_d    = out_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;

    s_axis_tready_o = 1'b0;
    st_we     = 1'b0;
    st_widx   = line_q;
    st_wdata  = nst_q;
    st_sel    = line_q;
    tag_we    = 1'b0;
    tag_re    = 1'b0;
    tag_waddr = fifo_q;
    tag_raddr = scan_q;
    dat_we    = 1'b0;
    dat_re    = 1'b0;
    dat_addr  = DAW'({line_q, w_q});
    dat_wdata = word_q[w_q];

    case (fsm_q)
      mesi_pkg::FSM_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_d    = s_axis_tuser_i[2:0];
          kind_d   = s_axis_tuser_i[4:3];
          addr_d   = s_axis_tdata_i[15:0];
          nst_d    = s_axis_tdata_i[273:272];
          scan_d   = '0;
          cmp_v_d  = 1'b0;
          fill_d   = (s_axis_tuser_i[2:0] == mesi_pkg::CMD_FILL);
          single_d = (s_axis_tuser_i[2:0] == mesi_pkg::CMD_RD_WORD);
          pend_d   = '0;
          pend_d.last = 1'b1;
          if (s_axis_tuser_i[2:0] == mesi_pkg::CMD_FILL) begin
            fsm_d = mesi_pkg::FSM_TAG;
          end else if (s_axis_tuser_i[2:0] == mesi_pkg::CMD_RD_WORD ||
                       s_axis_tuser_i[2:0] == mesi_pkg::CMD_WR_WORD ||
                       s_axis_tuser_i[2:0] == mesi_pkg::CMD_RD_LINE ||
                       s_axis_tuser_i[2:0] == mesi_pkg::CMD_SNOOP) begin
            fsm_d = mesi_pkg::FSM_SCAN;
          end else begin
            fsm_d = mesi_pkg::FSM_ONE;
          end
        end
      end
      mesi_pkg::FSM_SCAN: begin
        tag_re  = 1'b1;
        st_sel  = cmp_q;
        cmp_d   = scan_q;
        cmp_v_d = 1'b1;
        if (scan_q != LAST_LINE) begin
          scan_d = scan_q + 1'b1;
        end
        if (cmp_v_q) begin
          if (match) begin
            found_d = 1'b1;
            line_d  = cmp_q;
            fsm_d   = mesi_pkg::FSM_ACT;
          end else if (cmp_q == LAST_LINE) begin
            found_d = 1'b0;
            fsm_d   = mesi_pkg::FSM_ACT;
          end
        end
      end
      mesi_pkg::FSM_TAG: begin
        tag_re    = 1'b1;
        tag_raddr = fifo_q;
        fsm_d     = mesi_pkg::FSM_FILL;
      end
      mesi_pkg::FSM_FILL: begin
        st_sel   = fifo_q;
        dirty_d  = (st_rd == mesi_pkg::MESI_M);
        wbaddr_d = {tag_rdata, 2'b00};
        tag_we   = 1'b1;
        st_we    = 1'b1;
        st_widx  = fifo_q;
        fifo_d   = (fifo_q == LAST_LINE) ? '0 : fifo_q + 1'b1;
        miss_d   = miss_q + 32'd1;
        line_d   = fifo_q;
        w_d      = 2'd0;
        fsm_d    = mesi_pkg::FSM_RD;
      end
      mesi_pkg::FSM_ACT: begin
        pend_d      = '0;
        pend_d.last = 1'b1;
        pend_d.hit  = found_q;
        fsm_d       = mesi_pkg::FSM_ONE;
        case (cmd_q)
          mesi_pkg::CMD_RD_WORD: begin
            pend_d.widx = addr_q[1:0];
            if (found_q) begin
              w_d   = addr_q[1:0];
              fsm_d = mesi_pkg::FSM_RD;
            end
          end
          mesi_pkg::CMD_WR_WORD: begin
            pend_d.widx = addr_q[1:0];
            dat_addr    = DAW'({line_q, addr_q[1:0]});
            dat_wdata   = word_q[0];
            if (found_q) begin
              dat_we = 1'b1;
              st_we  = 1'b1;
            end
          end
          mesi_pkg::CMD_RD_LINE: begin
            if (found_q) begin
              w_d   = 2'd0;
              fsm_d = mesi_pkg::FSM_RD;
            end
          end
          mesi_pkg::CMD_SNOOP: begin
            if (found_q) begin
              pend_d.snoop = mesi_pkg::SRES_PRESENT;
              if (kind_q == mesi_pkg::SNOOP_BUS_RD) begin
                if (st_rd == mesi_pkg::MESI_M) begin
                  pend_d.snoop = mesi_pkg::SRES_FLUSH;
                end
                st_we    = 1'b1;
                st_wdata = mesi_pkg::MESI_S;
              end else if (kind_q == mesi_pkg::SNOOP_BUS_WR) begin
                st_we    = 1'b1;
                st_wdata = mesi_pkg::MESI_I;
                inv_d    = inv_q + 32'd1;
              end
            end
          end
          default: begin
            pend_d.hit = 1'b0;
          end
        endcase
      end
      mesi_pkg::FSM_RD: begin
        dat_re = 1'b1;
        dat_we = fill_q;
        if (!fill_q || dirty_q) begin
          fsm_d = mesi_pkg::FSM_EMIT;
        end else if (w_q == 2'd3) begin
          fsm_d = mesi_pkg::FSM_ONE;
        end else begin
          w_d = w_q + 2'd1;
        end
      end
      mesi_pkg::FSM_EMIT: begin
        if (out_free) begin
          ovalid_d     = 1'b1;
          out_d.hit    = !fill_q;
          out_d.data   = dat_rdata;
          out_d.widx   = w_q;
          out_d.wb     = fill_q;
          out_d.wbaddr = fill_q ? wbaddr_q : 16'd0;
          out_d.snoop  = mesi_pkg::SRES_ABSENT;
          out_d.last   = single_q || (w_q == 2'd3);
          out_d.mcnt   = miss_q;
          out_d.icnt   = inv_q;
          if (single_q || (w_q == 2'd3)) begin
            fsm_d = mesi_pkg::FSM_IDLE;
          end else begin
            w_d   = w_q + 2'd1;
            fsm_d = mesi_pkg::FSM_RD;
          end
        end
      end
      mesi_pkg::FSM_ONE: begin
        if (out_free) begin
          ovalid_d   = 1'b1;
          out_d      = pend_q;
          out_d.mcnt = miss_q;
          out_d.icnt = inv_q;
          fsm_d      = mesi_pkg::FSM_IDLE;
        end
      end
      default: begin
        fsm_d = mesi_pkg::FSM_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {3'b000, out_q.icnt, out_q.mcnt, out_q.snoop, out_q.wbaddr,
                            out_q.widx, out_q.data, out_q.hit};
  assign m_axis_tuser_o  = out_q.wb;
  assign m_axis_tlast_o  = out_q.last;

endmodule

`default_nettype wire

FILE: hdl/mesi_chk.sv
// ----------------------------------------------------------------------------
// MESI cache port checker
// Watches the stream ports of the cache and flags broken result sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module mesi_chk (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid_i,
  input wire logic         s_axis_tready_o,
  input wire logic         m_axis_tvalid_o,
  input wire logic         m_axis_tready_i,
  input wire logic [151:0] m_axis_tdata_o,
  input wire logic [0:0]   m_axis_tuser_o,
  input wire logic         m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("result item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while the previous item is still in work");

  a_wb_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |->
      (!m_axis_tdata_o[0] && m_axis_tdata_o[84:83] == 2'd0))
    else $error("writeback item carries hit or snoop status");

  a_last_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> (m_axis_tdata_o[66:65] != 2'd3))
    else $error("fourth word of a line not marked last");

endmodule

bind mesi_fully_assoc_cache_fifo mesi_chk u_mesi_chk (.*);

`default_nettype wire
